[design/ifbsf_pkg.sv]
// Package for the information-frame byte-stuffing framer.
// Holds transfer payload types, register indexes, reset values and the emitter phase type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ifbsf_pkg;

  localparam int LENGTH_BITS_DEF = 12;
  localparam int LEN_OUT_W       = 12;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FLAG        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_SEQ0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_SEQ1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_FLAG_SUB = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_ESC_SUB = 3'd6;

  localparam logic [7:0] FLAG_RST         = 8'h7E;
  localparam logic [7:0] ADDRESS_RST      = 8'h03;
  localparam logic [7:0] CTRL_SEQ0_RST    = 8'h40;
  localparam logic [7:0] CTRL_SEQ1_RST    = 8'h00;
  localparam logic [7:0] ESCAPE_RST       = 8'h7D;
  localparam logic [7:0] ESC_FLAG_SUB_RST = 8'h5E;
  localparam logic [7:0] ESC_ESC_SUB_RST  = 8'h5D;
  localparam logic [7:0] CHECK_RST        = 8'h00;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_packet;
    logic       last_of_packet;
    logic       sequence_bit;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 end_of_run;
    logic                 end_of_frame;
    logic [LEN_OUT_W-1:0] frame_length;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_HDR_FLAG,
    PH_HDR_ADDR,
    PH_HDR_CTRL,
    PH_HDR_BCC1,
    PH_DATA,
    PH_DATA_SUB,
    PH_BCC2,
    PH_BCC2_SUB,
    PH_CLOSE
  } phase_t;

endpackage

`default_nettype wire

[design/info_frame_byte_stuffing_framer.sv]
// Latency: a transfer's first output byte is registered first in the hold register, then in the output register.
// Throughput: one output byte per cycle while out_stall is low; an input item yields 1 to 9
// bytes (header, stuffed byte, stuffed check, closing flag), issued one by one from the byte emitter.
// The next input is taken in the cycle its predecessor's last byte is issued.
// Reset (rst, synchronous): registers return to defaults, check and length clear, no data held.
`timescale 1ns / 1ps
`default_nettype none

module info_frame_byte_stuffing_framer
  import ifbsf_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data
);

  logic [7:0] flag_byte, address_byte, control_seq_zero, control_seq_one;
  logic [7:0] escape_byte, escaped_flag_sub, escaped_escape_sub;

  logic                   hold_valid;
  logic                   hold_valid_next;
  in_item_t               hold;
  phase_t                 phase;
  phase_t                 phase_next;
  logic [7:0]             running_check;
  logic [LENGTH_BITS-1:0] emitted_count;
  logic [LENGTH_BITS-1:0] count_inc;
  logic [LENGTH_BITS-1:0] slot_count;
  logic [LENGTH_BITS+LEN_OUT_W-1:0] count_wide;

  logic       out_ready, emit, load;
  logic [7:0] ctrl_byte;
  logic       data_flag, data_stuff, check_flag, check_stuff;
  logic [7:0] slot_byte;
  logic       slot_last, slot_eof;
  out_item_t  slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte          <= FLAG_RST;
      address_byte       <= ADDRESS_RST;
      control_seq_zero   <= CTRL_SEQ0_RST;
      control_seq_one    <= CTRL_SEQ1_RST;
      escape_byte        <= ESCAPE_RST;
      escaped_flag_sub   <= ESC_FLAG_SUB_RST;
      escaped_escape_sub <= ESC_ESC_SUB_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FLAG:         flag_byte          <= cfg_data;
        REG_ADDRESS:      address_byte       <= cfg_data;
        REG_CTRL_SEQ0:    control_seq_zero   <= cfg_data;
        REG_CTRL_SEQ1:    control_seq_one    <= cfg_data;
        REG_ESCAPE:       escape_byte        <= cfg_data;
        REG_ESC_FLAG_SUB: escaped_flag_sub   <= cfg_data;
        REG_ESC_ESC_SUB:  escaped_escape_sub <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_ready = !out_valid || !out_stall;
  assign emit      = hold_valid && out_ready;
  assign in_stall  = hold_valid && !(out_ready && slot_last);
  assign load      = in_valid && !in_stall;

  assign ctrl_byte   = hold.sequence_bit ? control_seq_one : control_seq_zero;
  assign data_flag   = hold.payload_byte == flag_byte;
  assign data_stuff  = data_flag || (hold.payload_byte == escape_byte);
  assign check_flag  = running_check == flag_byte;
  assign check_stuff = check_flag || (running_check == escape_byte);

  assign count_inc  = (&emitted_count) ? emitted_count : emitted_count + 1'b1;
  assign slot_count = (phase == PH_HDR_FLAG) ? LENGTH_BITS'(1) : count_inc;
  assign count_wide = {{LEN_OUT_W{1'b0}}, slot_count};

  always_comb begin
    phase_next = phase;
    if (emit) begin
      unique case (phase)
        PH_HDR_FLAG: phase_next = PH_HDR_ADDR;
        PH_HDR_ADDR: phase_next = PH_HDR_CTRL;
        PH_HDR_CTRL: phase_next = PH_HDR_BCC1;
        PH_HDR_BCC1: phase_next = PH_DATA;
        PH_DATA:     phase_next = data_stuff ? PH_DATA_SUB : PH_BCC2;
        PH_DATA_SUB: phase_next = PH_BCC2;
        PH_BCC2:     phase_next = check_stuff ? PH_BCC2_SUB : PH_CLOSE;
        PH_BCC2_SUB: phase_next = PH_CLOSE;
        PH_CLOSE:    phase_next = PH_CLOSE;
        default:     phase_next = PH_CLOSE;
      endcase
    end
    if (load) begin
      phase_next = in_data.first_of_packet ? PH_HDR_FLAG : PH_DATA;
    end
  end

  always_comb begin
    slot_byte = flag_byte;
    slot_last = 1'b0;
    slot_eof  = 1'b0;
    unique case (phase)
      PH_HDR_FLAG: slot_byte = flag_byte;
      PH_HDR_ADDR: slot_byte = address_byte;
      PH_HDR_CTRL: slot_byte = ctrl_byte;
      PH_HDR_BCC1: slot_byte = address_byte ^ ctrl_byte;
      PH_DATA: begin
        slot_byte = data_stuff ? escape_byte : hold.payload_byte;
        slot_last = !data_stuff && !hold.last_of_packet;
      end
      PH_DATA_SUB: begin
        slot_byte = data_flag ? escaped_flag_sub : escaped_escape_sub;
        slot_last = !hold.last_of_packet;
      end
      PH_BCC2:     slot_byte = check_stuff ? escape_byte : running_check;
      PH_BCC2_SUB: slot_byte = check_flag ? escaped_flag_sub : escaped_escape_sub;
      PH_CLOSE: begin
        slot_byte = flag_byte;
        slot_last = 1'b1;
        slot_eof  = 1'b1;
      end
      default: slot_last = 1'b1;
    endcase
  end

  always_comb begin
    slot.out_byte     = slot_byte;
    slot.end_of_run   = slot_last;
    slot.end_of_frame = slot_eof;
    slot.frame_length = count_wide[LEN_OUT_W-1:0];
  end

  always_comb begin
    hold_valid_next = hold_valid;
    if (emit && slot_last) begin
      hold_valid_next = 1'b0;
    end
    if (load) begin
      hold_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid    <= 1'b0;
      phase         <= PH_DATA;
      running_check <= CHECK_RST;
      emitted_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
      phase      <= phase_next;
      if (emit) begin
        unique case (phase)
          PH_HDR_FLAG: begin
            running_check <= CHECK_RST;
            emitted_count <= LENGTH_BITS'(1);
          end
          PH_DATA: begin
            running_check <= running_check ^ hold.payload_byte;
            emitted_count <= count_inc;
          end
          PH_CLOSE: begin
            running_check <= CHECK_RST;
            emitted_count <= '0;
          end
          default: emitted_count <= count_inc;
        endcase
      end
      if (out_ready) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= in_data;
    end
    if (emit) begin
      out_data <= slot;
    end
  end

`ifndef SYNTHESIS
  a_eof_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.end_of_frame |-> out_data.end_of_run)
    else $error("closing flag not marked as end of run");

  a_load_holds: assert property (@(posedge clk) disable iff (rst)
    load |=> hold_valid)
    else $error("accepted transfer not held");

  a_idle_takes: assert property (@(posedge clk) disable iff (rst)
    !hold_valid |-> !in_stall)
    else $error("input stalled with nothing held");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    emit && phase == PH_CLOSE |=> running_check == CHECK_RST && emitted_count == '0)
    else $error("frame state not cleared after closing flag");
`endif

endmodule

`default_nettype wire
